@@ src/radar_nbf_gate_detector_macros.svh @@
// ----------------------------------------------------------------------------
// NBF gate detector assertion macros
// Shared concurrent assertion forms used by the detector's RTL.
// ----------------------------------------------------------------------------
`ifndef RADAR_NBF_GATE_DETECTOR_MACROS_SVH
`define RADAR_NBF_GATE_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RNBF_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RNBF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/rnbf_pkg.sv @@
// ----------------------------------------------------------------------------
// NBF gate detector package
// Widths, register indexes and shared types of the detector.
// ----------------------------------------------------------------------------
package rnbf_pkg;

   localparam int MAX_WINDOW = 64;
   localparam int SLOT_W     = $clog2(MAX_WINDOW);
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
   localparam int SD_W       = 15;
   localparam int SUM_W      = SD_W + SLOT_W;
   localparam int DATA_W     = 16;
   localparam int WLEN_W     = 7;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STD_THRESHOLD       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_THRESHOLD     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REFL_THRESHOLD      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REFL_FILL_THRESHOLD = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_END_FRACTION        = 3'd5;

   localparam logic [WLEN_W-1:0]        RST_WINDOW_LENGTH       = 7'd8;
   localparam logic [SD_W-1:0]          RST_STD_THRESHOLD       = 15'd480;
   localparam logic signed [DATA_W-1:0] RST_PHASE_THRESHOLD     = 16'sd1600;
   localparam logic signed [DATA_W-1:0] RST_REFL_THRESHOLD      = 16'sd640;
   localparam logic signed [DATA_W-1:0] RST_REFL_FILL_THRESHOLD = 16'sd240;
   localparam logic [DATA_W-1:0]        RST_END_FRACTION        = 16'd63570;

   localparam logic [SD_W-1:0] SD_MAX = '1;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
   } win_stat_type;

endpackage

@@ src/radar_nbf_gate_detector.sv @@
// ----------------------------------------------------------------------------
// Radar NBF gate detector
// Flags beam-filling range gates along a radial from phase, its standard
// deviation window, reflectivity and the LTAR and DR masks.
// ----------------------------------------------------------------------------
// Usage:
// Gates enter on the req_ channel in order along a radial, one transaction
// per gate; req_first_gate marks the first gate of a new radial and clears
// the window and the detection latch before that gate is processed. Each
// gate yields exactly one rsp_ transaction carrying rsp_nbf_flag.
// The block takes one gate per cycle while the output is not stalled. A gate
// updates the window cell chain in the cycle it is accepted and is held in
// the window stage; its flag is registered in the output register when that
// register is free or being taken, and rsp_valid rises with it. The output
// register and the window stage part the two sides, so a new gate is taken
// while a finished result waits. When rsp_stall is held, the result holds
// and req_stall rises once the window stage is full.
// Configuration is written through csr_we, csr_index and csr_wdata while the
// block is idle; unknown indexes are ignored. Synchronous reset clears the
// window count and sum, the latch and both valid flags, and restores the
// register defaults. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "radar_nbf_gate_detector_macros.svh"

module radar_nbf_gate_detector
   import rnbf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_first_gate,
   input  logic signed [DATA_W-1:0] req_refl,
   input  logic                     req_refl_valid,
   input  logic signed [DATA_W-1:0] req_phase,
   input  logic signed [DATA_W-1:0] req_phase_end,
   input  logic [SD_W-1:0]          req_std_phase,
   input  logic                     req_ltar_flag,
   input  logic                     req_dr_flag,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_nbf_flag,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DATA_W-1:0]        csr_wdata
);

   logic [WLEN_W-1:0]        window_length_ff;
   logic [SD_W-1:0]          std_threshold_ff;
   logic signed [DATA_W-1:0] phase_threshold_ff;
   logic signed [DATA_W-1:0] refl_threshold_ff;
   logic signed [DATA_W-1:0] refl_fill_threshold_ff;
   logic [DATA_W-1:0]        end_fraction_ff;

   logic accept;
   logic out_ready;
   logic s1_move;

   win_stat_type stat_next;

   logic                       s1_valid_ff;
   logic                       s1_valid_in;
   logic                       s1_first_ff;
   logic                       s1_refl_ok_ff;
   logic signed [DATA_W-1:0]   s1_refl_ff;
   logic signed [DATA_W-1:0]   s1_phase_ff;
   logic                       s1_sd_nz_ff;
   logic                       s1_ltar_ff;
   logic                       s1_dr_ff;
   win_stat_type               s1_stat_ff;
   logic signed [2*DATA_W:0]   s1_end_prod_ff;
   logic signed [2*DATA_W:0]   end_prod_in;

   logic                       detected_latch_ff;
   logic                       detected_latch_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       rsp_flag_ff;
   logic                       flag_in;

   logic                       latch_cur;
   logic                       detect;
   logic signed [2*DATA_W:0]   phase_scaled;
   logic [SD_W+CNT_W-1:0]      limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff       <= RST_WINDOW_LENGTH;
         std_threshold_ff       <= RST_STD_THRESHOLD;
         phase_threshold_ff     <= RST_PHASE_THRESHOLD;
         refl_threshold_ff      <= RST_REFL_THRESHOLD;
         refl_fill_threshold_ff <= RST_REFL_FILL_THRESHOLD;
         end_fraction_ff        <= RST_END_FRACTION;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: begin
               window_length_ff <= csr_wdata[WLEN_W-1:0];
            end
            CSR_STD_THRESHOLD: begin
               std_threshold_ff <= csr_wdata[SD_W-1:0];
            end
            CSR_PHASE_THRESHOLD: begin
               phase_threshold_ff <= csr_wdata;
            end
            CSR_REFL_THRESHOLD: begin
               refl_threshold_ff <= csr_wdata;
            end
            CSR_REFL_FILL_THRESHOLD: begin
               refl_fill_threshold_ff <= csr_wdata;
            end
            CSR_END_FRACTION: begin
               end_fraction_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_ready;
   assign req_stall = s1_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   rnbf_window u_window (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .first_gate    (req_first_gate),
      .std_phase     (req_std_phase),
      .window_length (window_length_ff),
      .stat_next     (stat_next)
   );

   assign end_prod_in = (2*DATA_W+1)'(req_phase_end)
                        * $signed((2*DATA_W+1)'({1'b0, end_fraction_ff}));

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      latch_cur    = s1_first_ff ? 1'b0 : detected_latch_ff;
      phase_scaled = {s1_phase_ff[DATA_W-1], s1_phase_ff, {DATA_W{1'b0}}};
      limit        = (SD_W+CNT_W)'(std_threshold_ff) * (SD_W+CNT_W)'(s1_stat_ff.count);
      detect       = s1_refl_ok_ff && !latch_cur
                     && (phase_scaled < s1_end_prod_ff)
                     && ((SD_W+CNT_W)'(s1_stat_ff.sum) < limit)
                     && s1_sd_nz_ff
                     && (s1_phase_ff > phase_threshold_ff)
                     && (s1_refl_ff > refl_threshold_ff)
                     && s1_ltar_ff && !s1_dr_ff;
      detected_latch_in = latch_cur || detect;
      flag_in = detect || (s1_refl_ok_ff && detected_latch_in
                           && (s1_refl_ff > refl_fill_threshold_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         detected_latch_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_move) begin
            detected_latch_ff <= detected_latch_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_first_ff    <= req_first_gate;
         s1_refl_ok_ff  <= req_refl_valid;
         s1_refl_ff     <= req_refl;
         s1_phase_ff    <= req_phase;
         s1_sd_nz_ff    <= (req_std_phase != '0);
         s1_ltar_ff     <= req_ltar_flag;
         s1_dr_ff       <= req_dr_flag;
         s1_stat_ff     <= stat_next;
         s1_end_prod_ff <= end_prod_in;
      end
      if (s1_move) begin
         rsp_flag_ff <= flag_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_nbf_flag = rsp_flag_ff;

   `RNBF_ASSERT_NEXT(a_flag_sets_latch, clock, reset, s1_move && flag_in, detected_latch_ff, "flagged gate left the detection latch clear")
   `RNBF_ASSERT_IMPLIES(a_count_range, clock, reset, s1_valid_ff, (s1_stat_ff.count != '0) && (s1_stat_ff.count <= CNT_W'(MAX_WINDOW)), "window count out of range")
   `RNBF_ASSERT_IMPLIES(a_sum_bound, clock, reset, s1_valid_ff, (SD_W+CNT_W)'(s1_stat_ff.sum) <= SD_MAX * s1_stat_ff.count, "window sum exceeds its fill")
   `RNBF_ASSERT_IMPLIES(a_accept_drains, clock, reset, accept && s1_valid_ff, s1_move, "transaction accepted over a held window stage")

endmodule

@@ src/rnbf_cell.sv @@
// ----------------------------------------------------------------------------
// NBF window cell
// One entry of the phase-std window; loads a new value or takes its
// neighbor's value as the window slides toward the head of the chain.
// ----------------------------------------------------------------------------
module rnbf_cell
   import rnbf_pkg::*;
(
   input  logic            clock,
   input  logic            load_en,
   input  logic            shift_en,
   input  logic [SD_W-1:0] load_value,
   input  logic [SD_W-1:0] shift_value,
   output logic [SD_W-1:0] value
);

   logic [SD_W-1:0] value_ff;
   logic [SD_W-1:0] value_in;

   always_comb begin
      if (load_en) begin
         value_in = load_value;
      end else if (shift_en) begin
         value_in = shift_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

@@ src/rnbf_window.sv @@
// ----------------------------------------------------------------------------
// NBF sliding window
// Chain of window cells with the running sum and fill count. The oldest
// entry always sits in the head cell, so the value that leaves is a fixed tap.
// ----------------------------------------------------------------------------
module rnbf_window
   import rnbf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              first_gate,
   input  logic [SD_W-1:0]   std_phase,
   input  logic [WLEN_W-1:0] window_length,
   output win_stat_type      stat_next
);

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  sum_in;
   logic [CNT_W-1:0]  len;
   logic [CNT_W-1:0]  count_base;
   logic [SUM_W-1:0]  sum_base;
   logic              drop;
   logic [SLOT_W-1:0] pos;
   logic [SUM_W-1:0]  head_ext;
   logic [SD_W-1:0]   cell_value [MAX_WINDOW];

   always_comb begin
      if (window_length == '0) begin
         len = CNT_W'(1);
      end else if (window_length > WLEN_W'(MAX_WINDOW)) begin
         len = CNT_W'(MAX_WINDOW);
      end else begin
         len = CNT_W'(window_length);
      end
      count_base = first_gate ? '0 : count_ff;
      sum_base   = first_gate ? '0 : sum_ff;
      drop       = (count_base >= len);
      pos        = drop ? SLOT_W'(count_base - CNT_W'(1)) : SLOT_W'(count_base);
      head_ext   = drop ? SUM_W'(cell_value[0]) : '0;
      sum_in     = sum_base - head_ext + SUM_W'(std_phase);
      count_in   = drop ? count_base : count_base + CNT_W'(1);
   end

   genvar i;
   generate
      for (i = 0; i < MAX_WINDOW; i++) begin : g_cell
         logic [SD_W-1:0] neighbor;
         if (i == MAX_WINDOW - 1) begin : g_tail
            assign neighbor = '0;
         end else begin : g_body
            assign neighbor = cell_value[i+1];
         end
         rnbf_cell u_cell (
            .clock       (clock),
            .load_en     (accept && (pos == SLOT_W'(i))),
            .shift_en    (accept && drop),
            .load_value  (std_phase),
            .shift_value (neighbor),
            .value       (cell_value[i])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (accept) begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   assign stat_next.sum   = sum_in;
   assign stat_next.count = count_in;

endmodule

@@ bench/radar_nbf_gate_detector_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NBF gate detector testbench
// Drives range gates through the detector under several register settings,
// with random gaps and stalls on both channels. Each gate's expected flag
// comes from a typed-in value or from a behavioral model of the window,
// latch and threshold tests, and is compared in order with the responses.
// ----------------------------------------------------------------------------
module radar_nbf_gate_detector_tb;
   import rnbf_pkg::*;

   localparam int PREDICTED   = -1;
   localparam int PHASE_COUNT = 12;
   localparam int PHASE_GATES = 42;

   typedef struct packed {
      logic                     first;
      logic signed [DATA_W-1:0] refl;
      logic                     refl_ok;
      logic signed [DATA_W-1:0] phase;
      logic signed [DATA_W-1:0] phase_end;
      logic [SD_W-1:0]          sd;
      logic                     ltar;
      logic                     dr;
      int                       flag;
   } gate_type;

   typedef struct packed {
      logic [WLEN_W-1:0]        wlen;
      logic [SD_W-1:0]          std_thr;
      logic signed [DATA_W-1:0] phase_thr;
      logic signed [DATA_W-1:0] refl_thr;
      logic signed [DATA_W-1:0] fill_thr;
      logic [DATA_W-1:0]        end_frac;
   } csr_set_type;

   typedef struct packed {
      int   tag;
      logic flag;
   } due_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_first_gate;
   logic signed [DATA_W-1:0] req_refl;
   logic                     req_refl_valid;
   logic signed [DATA_W-1:0] req_phase;
   logic signed [DATA_W-1:0] req_phase_end;
   logic [SD_W-1:0]          req_std_phase;
   logic                     req_ltar_flag;
   logic                     req_dr_flag;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_nbf_flag;
   logic                     csr_we;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [DATA_W-1:0]        csr_wdata;

   radar_nbf_gate_detector u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_first_gate (req_first_gate),
      .req_refl       (req_refl),
      .req_refl_valid (req_refl_valid),
      .req_phase      (req_phase),
      .req_phase_end  (req_phase_end),
      .req_std_phase  (req_std_phase),
      .req_ltar_flag  (req_ltar_flag),
      .req_dr_flag    (req_dr_flag),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_nbf_flag   (rsp_nbf_flag),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Register copies and window state of the behavioral model.
   logic [WLEN_W-1:0]        cfg_wlen      = RST_WINDOW_LENGTH;
   logic [SD_W-1:0]          cfg_std_thr   = RST_STD_THRESHOLD;
   logic signed [DATA_W-1:0] cfg_phase_thr = RST_PHASE_THRESHOLD;
   logic signed [DATA_W-1:0] cfg_refl_thr  = RST_REFL_THRESHOLD;
   logic signed [DATA_W-1:0] cfg_fill_thr  = RST_REFL_FILL_THRESHOLD;
   logic [DATA_W-1:0]        cfg_end_frac  = RST_END_FRACTION;

   logic [SD_W-1:0] win_store [MAX_WINDOW];
   longint          win_sum    = 0;
   int              win_count  = 0;
   int              win_slot   = 0;
   logic            latched    = 1'b0;

   due_type flag_due_q [$];
   due_type head;
   int      fail_count  = 0;
   int      sent        = 0;
   int      radial_left = 0;
   bit      no_gaps     = 1'b0;

   gate_type gate_rows [25] = '{
      '{1,    800, 1,   2000,   4000,   100, 1, 0, 1},
      '{0,    300, 1,      0,      0,     0, 0, 1, 1},
      '{0,    240, 1,   2000,   4000,   100, 1, 0, 0},
      '{0,  32767, 0,   2000,   4000,   100, 1, 0, 0},
      '{1,    300, 1,      0,      0,   100, 1, 0, 0},
      '{1,    800, 1,   2000,   4000,   100, 1, 1, 0},
      '{1,    800, 1,   2000,   4000,   100, 0, 0, 0},
      '{1,    800, 1,   2000,   4000,     0, 1, 0, 0},
      '{1,    800, 1,   2000,   4000, 32767, 1, 0, 0},
      '{1,    800, 1,   1600,   4000,   100, 1, 0, 0},
      '{1,    640, 1,   2000,   4000,   100, 1, 0, 0},
      '{1,    800, 1,   2000,   2000,   100, 1, 0, 0},
      '{1,  32767, 1,  32767,  32767,     1, 1, 0, 0},
      '{1, -32768, 1, -32768, -32768, 32767, 0, 1, 0},
      '{1,    800, 0,   2000,   4000,   100, 1, 0, 0},
      '{1,    800, 1,   2000,   4000,   600, 1, 0, PREDICTED},
      '{0,    800, 1,   2000,   4000,   100, 1, 0, PREDICTED},
      '{0,    200, 1,   2000,   4000,   100, 1, 0, PREDICTED},
      '{0,    241, 1,     -1,  32767, 16383, 1, 0, PREDICTED},
      '{0,    800, 1,   2000,   4000,   100, 1, 0, PREDICTED},
      '{1,    800, 1,   2000,   4000,  5000, 1, 0, PREDICTED},
      '{0,    800, 1,   2000,   4000,    10, 1, 0, PREDICTED},
      '{0,    800, 1,   2000,   4000, 21845, 1, 0, PREDICTED},
      '{0,    800, 1,   2000,   4000, 10922, 1, 0, PREDICTED},
      '{0,    800, 1,   2000,   4000,    10, 1, 0, PREDICTED}
   };

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic predict_nbf(input gate_type g);
      int     span;
      int     oldest;
      longint lhs;
      longint rhs;
      logic   flag;
      if (g.first) begin
         win_sum   = 0;
         win_count = 0;
         win_slot  = 0;
         latched   = 1'b0;
      end
      span = int'(cfg_wlen);
      if (span < 1) span = 1;
      if (span > MAX_WINDOW) span = MAX_WINDOW;
      if (win_count + 1 > span && win_count > 0) begin
         oldest  = (win_slot + MAX_WINDOW - win_count) % MAX_WINDOW;
         win_sum -= win_store[oldest];
      end else begin
         win_count++;
      end
      win_store[win_slot] = g.sd;
      win_sum += g.sd;
      win_slot = (win_slot + 1) % MAX_WINDOW;
      flag = 1'b0;
      if (g.refl_ok) begin
         lhs = longint'($signed(g.phase)) * 65536;
         rhs = longint'($signed(g.phase_end)) * longint'(cfg_end_frac);
         if (!latched && lhs < rhs && win_sum < longint'(cfg_std_thr) * win_count &&
             g.sd != 0 && $signed(g.phase) > $signed(cfg_phase_thr) &&
             $signed(g.refl) > $signed(cfg_refl_thr) && g.ltar && !g.dr) begin
            flag    = 1'b1;
            latched = 1'b1;
         end
         if (latched && $signed(g.refl) > $signed(cfg_fill_thr)) flag = 1'b1;
      end
      return flag;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat16(input int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[DATA_W-1:0];
   endfunction

   function automatic gate_type random_gate();
      gate_type g;
      int       lo;
      int       hi;
      int       p;
      int       top;
      if (radial_left == 0) begin
         g.first     = 1'b1;
         radial_left = ($urandom_range(0, 7) == 0) ? $urandom_range(65, 90)
                                                   : $urandom_range(3, 40);
      end else begin
         g.first = ($urandom_range(0, 39) == 0);
      end
      radial_left--;
      g.flag = PREDICTED;
      if ($urandom_range(0, 3) == 0) begin
         g.first     = 1'($urandom_range(0, 1));
         g.refl      = DATA_W'($urandom);
         g.refl_ok   = 1'($urandom_range(0, 1));
         g.phase     = DATA_W'($urandom);
         g.phase_end = DATA_W'($urandom);
         g.sd        = SD_W'($urandom);
         g.ltar      = 1'($urandom_range(0, 1));
         g.dr        = 1'($urandom_range(0, 1));
         return g;
      end
      lo = int'(cfg_refl_thr) < int'(cfg_fill_thr) ? int'(cfg_refl_thr) : int'(cfg_fill_thr);
      hi = int'(cfg_refl_thr) < int'(cfg_fill_thr) ? int'(cfg_fill_thr) : int'(cfg_refl_thr);
      g.refl    = sat16(lo - 64 + int'($urandom_range(0, hi - lo + 400)));
      g.refl_ok = ($urandom_range(0, 9) != 0);
      g.phase   = sat16(int'(cfg_phase_thr) - 64 + int'($urandom_range(0, 1000)));
      p         = int'(g.phase);
      if (cfg_end_frac == 16'd32768 && $urandom_range(0, 3) == 0)
         g.phase_end = sat16(2 * p);
      else
         g.phase_end = sat16(p + int'($urandom_range(0, (p < 0 ? -p : p) + 3000)));
      top = 2 * int'(cfg_std_thr) + 1;
      if (top > 32767) top = 32767;
      g.sd   = ($urandom_range(0, 15) == 0) ? '0 : SD_W'($urandom_range(1, top));
      g.ltar = ($urandom_range(0, 19) > 2);
      g.dr   = ($urandom_range(0, 7) == 0);
      return g;
   endfunction

   function automatic csr_set_type phase_setting(input int idx);
      csr_set_type s;
      s = '{RST_WINDOW_LENGTH, RST_STD_THRESHOLD, RST_PHASE_THRESHOLD,
            RST_REFL_THRESHOLD, RST_REFL_FILL_THRESHOLD, RST_END_FRACTION};
      case (idx)
         1: s.wlen = 7'd1;
         2: s.wlen = 7'd0;
         3: s.wlen = 7'd64;
         4: begin
            s.wlen    = 7'd127;
            s.std_thr = SD_MAX;
         end
         5: s.wlen = 7'd3;
         6: begin
            s.std_thr   = '0;
            s.phase_thr = -16'sd32768;
            s.refl_thr  = -16'sd32768;
            s.fill_thr  = -16'sd32768;
         end
         7: begin
            s.wlen      = 7'd5;
            s.phase_thr = 16'sd32767;
            s.refl_thr  = 16'sd32767;
            s.fill_thr  = 16'sd32767;
         end
         8: begin
            s.end_frac  = '0;
            s.phase_thr = -16'sd2000;
         end
         9: s.end_frac = 16'd32768;
         10: begin
            s.wlen     = 7'd2;
            s.end_frac = 16'hFFFF;
         end
         default: begin
            s.wlen      = WLEN_W'($urandom_range(0, 127));
            s.std_thr   = SD_W'($urandom_range(0, 2000));
            s.phase_thr = sat16(int'($urandom_range(0, 6000)) - 3000);
            s.refl_thr  = sat16(int'($urandom_range(0, 2000)) - 500);
            s.fill_thr  = sat16(int'($urandom_range(0, 2000)) - 1000);
            s.end_frac  = DATA_W'($urandom_range(40000, 65535));
         end
      endcase
      return s;
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_WINDOW_LENGTH:       cfg_wlen      = value[WLEN_W-1:0];
         CSR_STD_THRESHOLD:       cfg_std_thr   = value[SD_W-1:0];
         CSR_PHASE_THRESHOLD:     cfg_phase_thr = value;
         CSR_REFL_THRESHOLD:      cfg_refl_thr  = value;
         CSR_REFL_FILL_THRESHOLD: cfg_fill_thr  = value;
         CSR_END_FRACTION:        cfg_end_frac  = value;
         default: ;
      endcase
   endtask

   task automatic load_settings(input csr_set_type s);
      csr_write(CSR_WINDOW_LENGTH, DATA_W'(s.wlen));
      csr_write(CSR_STD_THRESHOLD, DATA_W'(s.std_thr));
      csr_write(CSR_PHASE_THRESHOLD, s.phase_thr);
      csr_write(CSR_REFL_THRESHOLD, s.refl_thr);
      csr_write(CSR_REFL_FILL_THRESHOLD, s.fill_thr);
      csr_write(CSR_END_FRACTION, s.end_frac);
      @(negedge clock) csr_we <= 1'b0;
   endtask

   task automatic send_gate(input gate_type g);
      int      gap;
      logic    flag;
      due_type due;
      gap = no_gaps ? 0 : $urandom_range(0, 15);
      repeat (gap) @(negedge clock) req_valid <= 1'b0;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_first_gate <= g.first;
      req_refl       <= g.refl;
      req_refl_valid <= g.refl_ok;
      req_phase      <= g.phase;
      req_phase_end  <= g.phase_end;
      req_std_phase  <= g.sd;
      req_ltar_flag  <= g.ltar;
      req_dr_flag    <= g.dr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      flag     = predict_nbf(g);
      due.tag  = sent;
      due.flag = (g.flag == PREDICTED) ? flag : g.flag[0];
      flag_due_q.insert(flag_due_q.size(), due);
      sent++;
   endtask

   task automatic settle();
      @(negedge clock) req_valid <= 1'b0;
      while (flag_due_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_first_gate = 1'b0;
      req_refl       = '0;
      req_refl_valid = 1'b0;
      req_phase      = '0;
      req_phase_end  = '0;
      req_std_phase  = '0;
      req_ltar_flag  = 1'b0;
      req_dr_flag    = 1'b0;
      csr_we         = 1'b0;
      csr_index      = CSR_WINDOW_LENGTH;
      csr_wdata      = '0;
      repeat (4) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      foreach (gate_rows[i]) send_gate(gate_rows[i]);
      for (int ph = 1; ph <= PHASE_COUNT; ph++) begin
         settle();
         load_settings(phase_setting(ph));
         no_gaps = (ph % 4 == 2);
         repeat (PHASE_GATES) send_gate(random_gate());
      end
      settle();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && flag_due_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // The receiver stalls at random per transaction and twice holds off long
   // enough for the detector to fill up and stall its input.
   initial begin : rsp_side
      int n;
      int taken;
      rsp_stall = 1'b0;
      taken     = 0;
      @(negedge reset);
      forever begin
         n = no_gaps ? 0 : $urandom_range(0, 15);
         if (taken == 120 || taken == 330) n = 90;
         repeat (n) @(negedge clock) rsp_stall <= 1'b1;
         @(negedge clock) rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (flag_due_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected response transaction, nbf_flag=%0b", rsp_nbf_flag);
         end else begin
            head = flag_due_q[0];
            flag_due_q.delete(0);
            if (rsp_nbf_flag !== head.flag) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("gate %0d: nbf_flag expected %0b, got %0b",
                           head.tag, head.flag, rsp_nbf_flag);
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
